// ===== src/rrp_pkg.sv =====
// Package for the request record packer: types, constants and record helpers.
package rrp_pkg;

  localparam int RRP_BUF_BYTES = 64;
  localparam logic [15:0] RRP_TYPE_ALIAS = 16'd21;
  localparam logic [15:0] RRP_TYPE_MAX = 16'd7;
  localparam logic [2:0] RRP_TYPE_DIRECT = 3'd6;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2
  } rrp_op_t;

  typedef struct packed {
    logic latch;
    logic emit_start;
    logic rd_next;
    logic load_empty;
    logic wr;
    logic clear;
  } rrp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fits;
    logic       fill_zero;
    logic       wr_last;
    logic       rd_last;
    logic       out_free;
  } rrp_stat_t;

  function automatic logic [2:0] eff_type(input logic [15:0] raw);
    logic [2:0] eff;
    if (raw == RRP_TYPE_ALIAS) begin
      eff = 3'd1;
    end else if (raw <= RRP_TYPE_MAX) begin
      eff = raw[2:0];
    end else begin
      eff = 3'd0;
    end
    return eff;
  endfunction

  function automatic logic [2:0] rec_len(input logic [2:0] eff);
    logic [2:0] len;
    unique case (eff)
      3'd0:    len = 3'd7;
      3'd1:    len = 3'd5;
      3'd2:    len = 3'd3;
      3'd3:    len = 3'd1;
      3'd4:    len = 3'd3;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] rec_byte(
    input logic [2:0]  eff,
    input logic [2:0]  idx,
    input logic [15:0] raw,
    input logic [7:0]  m1,
    input logic [7:0]  m2,
    input logic [15:0] addr,
    input logic [15:0] data
  );
    logic [7:0] b;
    if (idx == 3'd0) begin
      b = raw[7:0];
    end else if (eff == RRP_TYPE_DIRECT) begin
      case (idx)
        3'd1:    b = addr[15:8];
        3'd2:    b = addr[7:0];
        3'd3:    b = data[15:8];
        default: b = data[7:0];
      endcase
    end else begin
      case (idx)
        3'd1:    b = m1;
        3'd2:    b = m2;
        3'd3:    b = addr[15:8];
        3'd4:    b = addr[7:0];
        3'd5:    b = data[15:8];
        default: b = data[7:0];
      endcase
    end
    return b;
  endfunction

endpackage

// ===== src/request_record_packer.sv =====
// Top level of the request record packer.
// An add item writes its record into the buffer when the record fits; on overflow
// the buffered bytes go out first after a RAM read, one byte per cycle unless the receiver stalls.
// An end item sends the buffered bytes, or a single status beat when the buffer is empty.
// One item is in work at a time; the byte drain is paced by the single buffer read port.
// Synchronous active-low reset empties the buffer and clears the message count.
module request_record_packer #(
  parameter int BUF_BYTES = rrp_pkg::RRP_BUF_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // req_type, module_first, module_second, reg_address, cmd_data
  input  logic [1:0]  in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // out_byte, msgs_sent
  output logic [1:0]  out_tuser, // has_byte, batch_done
  output logic        out_tlast
);
  import rrp_pkg::*;

  rrp_cmd_t  cmd;
  rrp_stat_t stat;

  rrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrp_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_flags (out_tuser),
    .out_last  (out_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== src/rrp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rrp_ctrl.sv =====
// Controller state machine for the request record packer.
module rrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrp_pkg::rrp_stat_t stat,
  output rrp_pkg::rrp_cmd_t  cmd
);
  import rrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DRAIN,
    S_WRITE,
    S_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ADD: begin
            if (stat.fits) begin
              state_nxt = S_WRITE;
            end else begin
              cmd.emit_start = 1'b1;
              state_nxt      = S_DRAIN;
            end
          end
          OP_END: begin
            if (stat.fill_zero) begin
              state_nxt = S_EMPTY;
            end else begin
              cmd.emit_start = 1'b1;
              state_nxt      = S_DRAIN;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.rd_next = 1'b1;
          if (stat.rd_last) begin
            state_nxt = (stat.op == OP_ADD) ? S_WRITE : S_IDLE;
          end
        end
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (stat.wr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/rrp_dp.sv =====
// Datapath: item registers, fill and message counters, buffer RAM, output register.
module rrp_dp #(
  parameter int BUF_BYTES = rrp_pkg::RRP_BUF_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_op,
  input  logic [63:0]       in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [23:0]       out_data,
  output logic [1:0]        out_flags,
  output logic              out_last,
  input  rrp_pkg::rrp_cmd_t  cmd,
  output rrp_pkg::rrp_stat_t stat
);
  import rrp_pkg::*;

  localparam int FW = $clog2(BUF_BYTES + 1);
  localparam int AW = $clog2(BUF_BYTES);

  logic [1:0]    op_r;
  logic [15:0]   raw_r;
  logic [7:0]    m1_r;
  logic [7:0]    m2_r;
  logic [15:0]   addr_r;
  logic [15:0]   data_r;
  logic [FW-1:0] fill_r;
  logic [15:0]   cnt_r;
  logic [2:0]    widx_r;
  logic [AW-1:0] ridx_r;
  logic          end_r;
  logic          ov_r;
  logic          ohas_r;
  logic [7:0]    obyte_r;
  logic          olast_r;
  logic          odone_r;
  logic [15:0]   ocnt_r;

  logic [2:0]    eff;
  logic [2:0]    len;
  logic          fits;
  logic          wr_last;
  logic          rd_last;
  logic          out_free;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;

  assign eff      = eff_type(raw_r);
  assign len      = rec_len(eff);
  assign fits     = ({1'b0, fill_r} + (FW + 1)'(len)) <= (FW + 1)'(BUF_BYTES);
  assign wr_last  = widx_r == (len - 3'd1);
  assign rd_last  = (FW'(ridx_r) + FW'(1)) == fill_r;
  assign out_free = !ov_r || out_ready;

  assign ram_re    = cmd.emit_start || (cmd.rd_next && !rd_last);
  assign ram_raddr = cmd.emit_start ? '0 : ridx_r + AW'(1);
  assign ram_waddr = AW'(fill_r + FW'(widx_r));
  assign ram_wdata = rec_byte(eff, widx_r, raw_r, m1_r, m2_r, addr_r, data_r);

  rrp_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // item fields and output payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      raw_r  <= in_data[15:0];
      m1_r   <= in_data[23:16];
      m2_r   <= in_data[31:24];
      addr_r <= in_data[47:32];
      data_r <= in_data[63:48];
    end
    if (cmd.emit_start) begin
      end_r <= (op_r == OP_END);
    end
    if (cmd.rd_next) begin
      ohas_r  <= 1'b1;
      obyte_r <= ram_q;
      olast_r <= rd_last;
      odone_r <= rd_last && end_r;
      ocnt_r  <= cnt_r;
    end else if (cmd.load_empty) begin
      ohas_r  <= 1'b0;
      obyte_r <= '0;
      olast_r <= 1'b0;
      odone_r <= 1'b1;
      ocnt_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
      widx_r <= '0;
      ridx_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        fill_r <= '0;
        cnt_r  <= '0;
      end
      if (cmd.emit_start) begin
        ridx_r <= '0;
        if (cnt_r != 16'hffff) begin
          cnt_r <= cnt_r + 16'd1;
        end
      end
      if (cmd.rd_next) begin
        ridx_r <= ridx_r + AW'(1);
        if (rd_last) begin
          fill_r <= '0;
        end
      end
      if (cmd.wr) begin
        if (wr_last) begin
          widx_r <= '0;
          fill_r <= fill_r + FW'(len);
        end else begin
          widx_r <= widx_r + 3'd1;
        end
      end
      if (cmd.rd_next || cmd.load_empty) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat           = '0;
    stat.op        = op_r;
    stat.fits      = fits;
    stat.fill_zero = (fill_r == '0);
    stat.wr_last   = wr_last;
    stat.rd_last   = rd_last;
    stat.out_free  = out_free;
  end

  assign out_valid = ov_r;
  assign out_data  = {ocnt_r, obyte_r};
  assign out_flags = {odone_r, ohas_r};
  assign out_last  = olast_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUF_BYTES))
    else $error("fill level beyond buffer size");

  a_write_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> fits)
    else $error("record written without room");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_next && rd_last) |=> (fill_r == '0))
    else $error("buffer not emptied after message");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ohas_r) |-> (ocnt_r != 16'd0))
    else $error("message byte with zero message count");
`endif

endmodule

// ===== tb/tb_request_record_packer.sv =====
// Self-checking testbench for request_record_packer: directed table and random traffic.
`timescale 1ns / 1ps

module tb_request_record_packer;
  import rrp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int REC_LEN [0:7] = '{7, 5, 3, 1, 3, 5, 5, 5};
  localparam int RAND_ITEMS = 250;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data_byte;
    logic        msg_last;
    logic        batch_done;
    logic [15:0] msgs_sent;
  } beat_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] raw;
    logic [7:0]  m1;
    logic [7:0]  m2;
    logic [15:0] addr;
    logic [15:0] data;
    logic        typed;
    beat_t       want;
  } req_t;

  localparam req_t DIRECTED [0:22] = '{
    '{OP_END,    16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1,
      '{1'b0, 8'h00, 1'b0, 1'b1, 16'd0}},
    '{OP_ADD,    16'h0003, 8'h41, 8'h42, 16'h1111, 16'h2222, 1'b0, '0},
    '{OP_END,    16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1,
      '{1'b1, 8'h03, 1'b1, 1'b1, 16'd1}},
    '{OP_ADD,    16'h0000, 8'hff, 8'hff, 16'hffff, 16'hffff, 1'b0, '0},
    '{OP_ADD,    16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_ADD,    16'h0001, 8'h12, 8'h34, 16'h5678, 16'h9abc, 1'b0, '0},
    '{OP_ADD,    16'h0002, 8'h21, 8'h43, 16'h6587, 16'hcba9, 1'b0, '0},
    '{OP_ADD,    16'h0004, 8'h13, 8'h57, 16'h9bdf, 16'h2468, 1'b0, '0},
    '{OP_ADD,    16'h0005, 8'h31, 8'h75, 16'hfdb9, 16'h8642, 1'b0, '0},
    '{OP_ADD,    16'h0006, 8'hee, 8'hee, 16'h1234, 16'habcd, 1'b0, '0},
    '{OP_ADD,    16'h0007, 8'h5a, 8'ha5, 16'h0f0f, 16'hf0f0, 1'b0, '0},
    '{OP_ADD,    RRP_TYPE_ALIAS, 8'h61, 8'h62, 16'h0102, 16'h0304, 1'b0, '0},
    '{OP_ADD,    16'h0008, 8'h71, 8'h72, 16'h0506, 16'h0708, 1'b0, '0},
    '{OP_ADD,    16'hffff, 8'h81, 8'h82, 16'h090a, 16'h0b0c, 1'b0, '0},
    '{OP_ADD,    16'h8000, 8'h91, 8'h92, 16'h0d0e, 16'h0f10, 1'b0, '0},
    '{OP_ADD,    16'h7fff, 8'ha1, 8'ha2, 16'h1112, 16'h1314, 1'b0, '0},
    '{OP_ADD,    16'h0014, 8'hb1, 8'hb2, 16'h1516, 16'h1718, 1'b0, '0},
    '{OP_ADD,    16'h0016, 8'hc1, 8'hc2, 16'h191a, 16'h1b1c, 1'b0, '0},
    '{OP_UNUSED, 16'h5a5a, 8'ha5, 8'h5a, 16'hffff, 16'hffff, 1'b0, '0},
    '{OP_END,    16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_ADD,    16'h0002, 8'hd1, 8'hd2, 16'h1d1e, 16'h1f20, 1'b0, '0},
    '{OP_CLEAR,  16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, '0},
    '{OP_END,    16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1,
      '{1'b0, 8'h00, 1'b0, 1'b1, 16'd0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // packer model state
  logic [7:0]  rec_buf [0:RRP_BUF_BYTES-1];
  int          buf_fill;
  logic [15:0] msg_count;
  beat_t       step_beats [$];
  beat_t       exp_beats [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_on;
  bit  hold_req;

  request_record_packer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void flush_buffer(input bit end_item);
    if (msg_count != 16'hffff) msg_count++;
    for (int i = 0; i < buf_fill; i++) begin
      step_beats.push_back('{1'b1, rec_buf[i], (i == buf_fill - 1),
                             end_item && (i == buf_fill - 1), msg_count});
    end
    buf_fill = 0;
  endfunction

  function automatic void pack_request(input req_t r);
    logic [2:0] kind;
    int         len;
    logic [7:0] rec [0:6];
    step_beats.delete();
    case (r.op)
      OP_ADD: begin
        if (r.raw == RRP_TYPE_ALIAS) kind = 3'd1;
        else if (r.raw <= RRP_TYPE_MAX) kind = r.raw[2:0];
        else kind = 3'd0;
        len = REC_LEN[kind];
        if (buf_fill + len > RRP_BUF_BYTES) flush_buffer(1'b0);
        rec[0] = r.raw[7:0];
        if (kind == RRP_TYPE_DIRECT) begin
          rec[1] = r.addr[15:8];
          rec[2] = r.addr[7:0];
          rec[3] = r.data[15:8];
          rec[4] = r.data[7:0];
        end else begin
          rec[1] = r.m1;
          rec[2] = r.m2;
          rec[3] = r.addr[15:8];
          rec[4] = r.addr[7:0];
          rec[5] = r.data[15:8];
          rec[6] = r.data[7:0];
        end
        for (int i = 0; i < len; i++) rec_buf[buf_fill + i] = rec[i];
        buf_fill += len;
      end
      OP_END: begin
        if (buf_fill > 0) flush_buffer(1'b1);
        else step_beats.push_back('{1'b0, 8'h00, 1'b0, 1'b1, msg_count});
      end
      OP_CLEAR: begin
        buf_fill = 0;
        msg_count = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_item(input logic [1:0] op, input logic [15:0] raw);
    req_t r;
    r = '0;
    r.op = op;
    r.raw = raw;
    r.m1 = 8'($urandom);
    r.m2 = 8'($urandom);
    r.addr = 16'($urandom);
    r.data = 16'($urandom);
    return r;
  endfunction

  function automatic req_t rand_item();
    int          sel;
    int          tsel;
    logic [1:0]  op;
    logic [15:0] raw;
    sel = $urandom_range(0, 99);
    tsel = $urandom_range(0, 9);
    if (sel < 76) op = OP_ADD;
    else if (sel < 92) op = OP_END;
    else if (sel < 96) op = OP_CLEAR;
    else op = OP_UNUSED;
    if (tsel < 8) raw = 16'(tsel);
    else if (tsel == 8) raw = RRP_TYPE_ALIAS;
    else raw = 16'($urandom);
    return make_item(op, raw);
  endfunction

  task automatic send_item(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r.data, r.addr, r.m2, r.m1, r.raw};
    in_tuser <= r.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pack_request(r);
    if (r.typed) exp_beats.push_back(r.want);
    else foreach (step_beats[k]) exp_beats.push_back(step_beats[k]);
  endtask

  task automatic wait_drained();
    while (exp_beats.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : result_check
    beat_t got;
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser[0], out_tdata[7:0], out_tlast, out_tuser[1], out_tdata[23:8]};
      if (exp_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected transfer, expected none, got 0x%0h", $time, got);
      end else begin
        want = exp_beats.pop_front();
        check_field("has_byte", int'(want.has_byte), int'(got.has_byte));
        check_field("out_byte", int'(want.data_byte), int'(got.data_byte));
        check_field("msg_last", int'(want.msg_last), int'(got.msg_last));
        check_field("batch_done", int'(want.batch_done), int'(got.batch_done));
        check_field("msgs_sent", int'(want.msgs_sent), int'(got.msgs_sent));
      end
    end
  end

  // receiver: random stall bursts, calm stretches, and one long hold on request
  initial begin : receiver
    int pick;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (hold_req && !held) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end else if (idle_on && pick == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else if (idle_on && pick == 1) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    idle_on = 1'b1;
    hold_req = 1'b0;
    buf_fill = 0;
    msg_count = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 180) wait_drained();
      if (n == 220) idle_on = 1'b0;
      send_item(rand_item());
    end

    send_item(make_item(OP_END, 16'd0));
    send_item(make_item(OP_CLEAR, 16'd0));
    send_item(make_item(OP_END, 16'd0));
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rrp_pkg.sv
src/rrp_ram.sv
src/rrp_ctrl.sv
src/rrp_dp.sv
src/request_record_packer.sv
tb/tb_request_record_packer.sv
